// ===== rtl/rps_pkg.sv =====
// Shared widths, constants and register codes for the RNS plaintext scale-up block.
package rps_pkg;

  localparam int XW = 64;            // internal coefficient and remainder width
  localparam int HW = XW / 2;        // half word used by the partial products
  localparam int QW = 61;            // prime and residue width
  localparam int KW = 7;             // plain_bits width
  localparam int PW = 2 * XW;        // full product width
  localparam int SW = 126;           // width of scaled product plus rounding term
  localparam int RED_BITS = 2;       // dividend bits consumed per reduction stage
  localparam int RED_STAGES = SW / RED_BITS;
  localparam int CFG_DW = 64;
  localparam int CFG_IW = 2;

  localparam logic [KW-1:0] K_MIN = KW'(2);
  localparam logic [KW-1:0] K_MAX = KW'(64);

  typedef enum logic [CFG_IW-1:0] {
    REG_PRIME      = 2'd0,
    REG_QUOT       = 2'd1,
    REG_REM        = 2'd2,
    REG_PLAIN_BITS = 2'd3
  } reg_idx_t;

endpackage

// ===== rtl/rns_plaintext_scale_up.sv =====
// Top level: returns round(Q/2^k * x) mod q for one RNS lane, one coefficient per beat.
// Pipeline, input beat to earliest output beat: 3 mul, 3 round and 63 reduce stages, then 1 output register.
// Throughput: one beat per cycle while the skid register is empty; the 63-stage reduction pipeline sets the latency.
// A skid register holds one more result while the output waits; input stalls while it is full.
// Synchronous active-high reset clears all valid bits and loads the register defaults.
module rns_plaintext_scale_up #(
  parameter int WORD_BITS = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [WORD_BITS-1:0]       coefficient,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [rps_pkg::QW-1:0]     residue,
  input  logic                       cfg_write,
  input  logic [rps_pkg::CFG_IW-1:0] cfg_index,
  input  logic [rps_pkg::CFG_DW-1:0] cfg_data
);

  logic [rps_pkg::QW-1:0] prime_modulus;
  logic [rps_pkg::QW-1:0] quotient_residue;
  logic [rps_pkg::XW-1:0] remainder_mod_plain;
  logic [rps_pkg::KW-1:0] plain_bits;

  logic [rps_pkg::KW-1:0] plain_bits_clamped;
  logic [rps_pkg::XW-1:0] rem_masked;
  logic [rps_pkg::XW-1:0] coef_ext;

  logic                   en;
  logic                   scaled_valid, round_valid, sum_valid, red_valid;
  logic [rps_pkg::PW-1:0] prod_scaled, prod_round;
  logic [rps_pkg::SW-1:0] sum;
  logic [rps_pkg::QW-1:0] red_rem, red_result;

  logic                   skid_valid;
  logic [rps_pkg::QW-1:0] skid_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      prime_modulus       <= rps_pkg::QW'(2);
      quotient_residue    <= '0;
      remainder_mod_plain <= '0;
      plain_bits          <= rps_pkg::KW'(2);
    end else if (cfg_write) begin
      case (rps_pkg::reg_idx_t'(cfg_index))
        rps_pkg::REG_PRIME:      prime_modulus       <= cfg_data[rps_pkg::QW-1:0];
        rps_pkg::REG_QUOT:       quotient_residue    <= cfg_data[rps_pkg::QW-1:0];
        rps_pkg::REG_REM:        remainder_mod_plain <= cfg_data[rps_pkg::XW-1:0];
        rps_pkg::REG_PLAIN_BITS: plain_bits          <= cfg_data[rps_pkg::KW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (plain_bits < rps_pkg::K_MIN) begin
      plain_bits_clamped = rps_pkg::K_MIN;
    end else if (plain_bits > rps_pkg::K_MAX) begin
      plain_bits_clamped = rps_pkg::K_MAX;
    end else begin
      plain_bits_clamped = plain_bits;
    end
  end

  // A shift by the full word width yields zero, so k of 64 keeps every bit.
  assign rem_masked = remainder_mod_plain & ~({rps_pkg::XW{1'b1}} << plain_bits_clamped);
  assign coef_ext   = rps_pkg::XW'(coefficient);

  // The whole pipeline advances unless the skid register is holding a result.
  assign en       = !skid_valid;
  assign in_ready = en;

  rps_mul u_mul_scaled (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid && in_ready),
    .a         (coef_ext),
    .b         (rps_pkg::XW'(quotient_residue)),
    .out_valid (scaled_valid),
    .prod      (prod_scaled)
  );

  rps_mul u_mul_round (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid && in_ready),
    .a         (rem_masked),
    .b         (coef_ext),
    .out_valid (round_valid),
    .prod      (prod_round)
  );

  rps_round u_round (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (scaled_valid && round_valid),
    .prod_scaled (prod_scaled),
    .prod_round  (prod_round),
    .plain_bits  (plain_bits_clamped),
    .out_valid   (sum_valid),
    .sum         (sum)
  );

  rps_modred u_modred (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sum_valid),
    .value     (sum),
    .prime     (prime_modulus),
    .out_valid (red_valid),
    .remainder (red_rem)
  );

  assign red_result = (prime_modulus == '0) ? '0 : red_rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !out_ready) begin
      if (en && red_valid) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= en && red_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !out_ready) begin
      if (en && red_valid) begin
        skid_data <= red_result;
      end
    end else if (skid_valid) begin
      residue <= skid_data;
    end else if (en && red_valid) begin
      residue <= red_result;
    end
  end

  a_skid_needs_output : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a beat while the output register is empty");

  a_skid_fill_on_stall : assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !out_ready))
    else $error("skid register filled while the output was not stalled");

  a_residue_reduced : assert property (@(posedge clk) disable iff (rst)
    out_valid && prime_modulus != '0 |-> residue < prime_modulus)
    else $error("residue is not reduced below the prime");

endmodule

// ===== rtl/rps_mul.sv =====
// Three-stage 64x64 multiplier built from four registered 32x32 partial products.
module rps_mul (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [rps_pkg::XW-1:0] a,
  input  logic [rps_pkg::XW-1:0] b,
  output logic                   out_valid,
  output logic [rps_pkg::PW-1:0] prod
);

  logic [rps_pkg::XW-1:0] p00, p01, p10, p11;
  logic [rps_pkg::XW-1:0] p00_d, p11_d;
  logic [rps_pkg::XW:0]   mid;
  logic [2:0]             valid_st;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_st <= '0;
    end else if (en) begin
      valid_st <= {valid_st[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p00 <= rps_pkg::XW'(a[rps_pkg::HW-1:0]) * rps_pkg::XW'(b[rps_pkg::HW-1:0]);
      p01 <= rps_pkg::XW'(a[rps_pkg::HW-1:0]) * rps_pkg::XW'(b[rps_pkg::XW-1:rps_pkg::HW]);
      p10 <= rps_pkg::XW'(a[rps_pkg::XW-1:rps_pkg::HW]) * rps_pkg::XW'(b[rps_pkg::HW-1:0]);
      p11 <= rps_pkg::XW'(a[rps_pkg::XW-1:rps_pkg::HW])
             * rps_pkg::XW'(b[rps_pkg::XW-1:rps_pkg::HW]);

      mid   <= (rps_pkg::XW+1)'(p01) + (rps_pkg::XW+1)'(p10);
      p00_d <= p00;
      p11_d <= p11;

      prod <= {p11_d, p00_d} + (rps_pkg::PW'(mid) << rps_pkg::HW);
    end
  end

  assign out_valid = valid_st[2];

endmodule

// ===== rtl/rps_round.sv =====
// Rounding term: adds half, shifts right by k, then adds the scaled product.
module rps_round (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [rps_pkg::PW-1:0] prod_scaled,
  input  logic [rps_pkg::PW-1:0] prod_round,
  input  logic [rps_pkg::KW-1:0] plain_bits,
  output logic                   out_valid,
  output logic [rps_pkg::SW-1:0] sum
);

  logic [rps_pkg::PW-1:0] rounded;
  logic [rps_pkg::XW-1:0] quot;
  logic [rps_pkg::SW-1:0] scaled_a, scaled_b;
  logic [2:0]             valid_st;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_st <= '0;
    end else if (en) begin
      valid_st <= {valid_st[1:0], in_valid};
    end
  end

  // The rounded product stays below 2^(k+64), so the shifted value fits a word.
  always_ff @(posedge clk) begin
    if (en) begin
      rounded  <= prod_round + (rps_pkg::PW'(1) << (plain_bits - rps_pkg::KW'(1)));
      scaled_a <= prod_scaled[rps_pkg::SW-1:0];

      quot     <= rps_pkg::XW'(rounded >> plain_bits);
      scaled_b <= scaled_a;

      sum <= scaled_b + rps_pkg::SW'(quot);
    end
  end

  assign out_valid = valid_st[2];

endmodule

// ===== rtl/rps_modred.sv =====
// Pipelined shift-and-subtract reduction of the summed value modulo the prime.
module rps_modred (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [rps_pkg::SW-1:0] value,
  input  logic [rps_pkg::QW-1:0] prime,
  output logic                   out_valid,
  output logic [rps_pkg::QW-1:0] remainder
);

  logic [rps_pkg::QW-1:0]         rem_st  [rps_pkg::RED_STAGES];
  logic [rps_pkg::SW-1:0]         rest_st [rps_pkg::RED_STAGES];
  logic [rps_pkg::RED_STAGES-1:0] valid_st;

  // One restoring step: bring in the next dividend bit and subtract the prime once if it fits.
  function automatic logic [rps_pkg::QW-1:0] red_step(input logic [rps_pkg::QW-1:0] r,
                                                     input logic                   b,
                                                     input logic [rps_pkg::QW-1:0] q);
    logic [rps_pkg::QW:0] t;
    t = {r, b};
    if (t >= {1'b0, q}) begin
      t = t - {1'b0, q};
    end
    return t[rps_pkg::QW-1:0];
  endfunction

  for (genvar j = 0; j < rps_pkg::RED_STAGES; j++) begin : g_stage
    logic [rps_pkg::QW-1:0] r_in;
    logic [rps_pkg::QW-1:0] r_next;
    logic [rps_pkg::SW-1:0] s_in;
    logic                   v_in;

    if (j == 0) begin : g_first
      assign r_in = '0;
      assign s_in = value;
      assign v_in = in_valid;
    end else begin : g_rest
      assign r_in = rem_st[j-1];
      assign s_in = rest_st[j-1];
      assign v_in = valid_st[j-1];
    end

    always_comb begin
      r_next = r_in;
      for (int b = 0; b < rps_pkg::RED_BITS; b++) begin
        r_next = red_step(r_next, s_in[rps_pkg::SW-1-b], prime);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_st[j] <= 1'b0;
      end else if (en) begin
        valid_st[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_st[j]  <= r_next;
        rest_st[j] <= s_in << rps_pkg::RED_BITS;
      end
    end
  end

  assign out_valid = valid_st[rps_pkg::RED_STAGES-1];
  assign remainder = rem_st[rps_pkg::RED_STAGES-1];

endmodule
